// ===== hw/rtl/jsc_pkg.sv =====
package jsc_pkg;

  localparam int unsigned MAX_DEPTH = 32;
  localparam int unsigned LEVEL_W   = $clog2(MAX_DEPTH + 1);
  localparam int unsigned IDX_W     = $clog2(MAX_DEPTH);
  localparam int unsigned NEST_W    = 6;

  typedef enum logic [1:0] {
    V_ACC  = 2'd0,
    V_WS   = 2'd1,
    V_REJ  = 2'd2,
    V_DEEP = 2'd3
  } verdict_e;

  typedef enum logic [3:0] {
    PH_OPEN   = 4'd0,
    PH_VALUE  = 4'd1,
    PH_AWAIT  = 4'd2,
    PH_CLOSED = 4'd3,
    PH_KEY    = 4'd4,
    PH_COLON  = 4'd5,
    PH_VWAIT  = 4'd6
  } phase_e;

  typedef enum logic [2:0] {
    K_NONE    = 3'd0,
    K_ARRAY   = 3'd1,
    K_OBJECT  = 3'd2,
    K_STRING  = 3'd3,
    K_NUMBER  = 3'd4,
    K_LITERAL = 3'd5
  } kind_e;

  // leaf state codes
  localparam logic [5:0] S_NONE    = 6'd0;
  localparam logic [5:0] S_OPEN    = 6'd1;
  localparam logic [5:0] S_ESC     = 6'd2;
  localparam logic [5:0] S_U0      = 6'd3;
  localparam logic [5:0] S_U1      = 6'd4;
  localparam logic [5:0] S_U2      = 6'd5;
  localparam logic [5:0] S_U3      = 6'd6;
  localparam logic [5:0] S_CLOSED  = 6'd7;
  localparam logic [5:0] N_NEG     = 6'd8;
  localparam logic [5:0] N_ZERO    = 6'd9;
  localparam logic [5:0] N_INT     = 6'd10;
  localparam logic [5:0] N_DEC     = 6'd11;
  localparam logic [5:0] N_FRAC    = 6'd12;
  localparam logic [5:0] N_EXP     = 6'd13;
  localparam logic [5:0] N_ESIGN   = 6'd14;
  localparam logic [5:0] N_EDIG    = 6'd15;
  localparam logic [5:0] LIT_BASE  = 6'd16;
  localparam logic [5:0] LIT_COUNT = 6'd13;
  localparam logic [5:0] LIT_FALSE = 6'd20;
  localparam logic [5:0] LIT_NULL  = 6'd25;
  localparam logic [5:0] LIT_TRUE_END  = 6'd19;
  localparam logic [5:0] LIT_FALSE_END = 6'd24;
  localparam logic [5:0] LIT_NULL_END  = 6'd28;

  // characters
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UE     = 8'h45;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSL    = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LB     = 8'h62;
  localparam logic [7:0] CH_LE     = 8'h65;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_LL     = 8'h6C;
  localparam logic [7:0] CH_LN     = 8'h6E;
  localparam logic [7:0] CH_LR     = 8'h72;
  localparam logic [7:0] CH_LS     = 8'h73;
  localparam logic [7:0] CH_LT     = 8'h74;
  localparam logic [7:0] CH_LU     = 8'h75;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef struct packed {
    logic       restart;
    logic [7:0] char_in;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]        verdict;
    logic              doc_valid;
    logic [NEST_W-1:0] nest_depth;
  } out_beat_t;

  typedef struct packed {
    logic   obj;
    phase_e ph;
  } frame_t;

  typedef struct packed {
    frame_t             top;
    logic [LEVEL_W-1:0] level;
    logic               root_chosen;
    logic [5:0]         leaf_state;
    logic               leaf_active;
  } state_t;

  typedef struct packed {
    logic   we;
    frame_t frame;
  } push_t;

  localparam state_t STATE_RESET = '{
    top:         '{obj: 1'b0, ph: PH_OPEN},
    level:       '0,
    root_chosen: 1'b0,
    leaf_state:  S_NONE,
    leaf_active: 1'b0
  };

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_dig(c) || (c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF);
  endfunction

  function automatic kind_e value_kind(input logic [7:0] c);
    kind_e k;
    k = K_NONE;
    if (c == CH_LBRACK) k = K_ARRAY;
    else if (c == CH_LBRACE) k = K_OBJECT;
    else if (c == CH_QUOTE) k = K_STRING;
    else if (c == CH_MINUS || is_dig(c)) k = K_NUMBER;
    else if (c == CH_LT || c == CH_LF || c == CH_LN) k = K_LITERAL;
    return k;
  endfunction

  function automatic logic leaf_valid(input logic [5:0] s);
    return s == S_CLOSED || s == N_ZERO || s == N_INT || s == N_FRAC || s == N_EDIG ||
           s == LIT_TRUE_END || s == LIT_FALSE_END || s == LIT_NULL_END;
  endfunction

  // next expected byte of a literal word, zero once the word is done
  function automatic logic [7:0] lit_next(input logic [5:0] i);
    logic [7:0] e;
    case (i)
      6'd0:    e = CH_LR;
      6'd1:    e = CH_LU;
      6'd2:    e = CH_LE;
      6'd4:    e = CH_LA;
      6'd5:    e = CH_LL;
      6'd6:    e = CH_LS;
      6'd7:    e = CH_LE;
      6'd9:    e = CH_LU;
      6'd10:   e = CH_LL;
      6'd11:   e = CH_LL;
      default: e = 8'h00;
    endcase
    return e;
  endfunction

  function automatic logic [5:0] leaf_start(input logic [7:0] c);
    logic [5:0] s;
    if (c == CH_QUOTE) s = S_OPEN;
    else if (c == CH_MINUS) s = N_NEG;
    else if (c == CH_0) s = N_ZERO;
    else if (is_dig(c)) s = N_INT;
    else if (c == CH_LT) s = LIT_BASE;
    else if (c == CH_LF) s = LIT_FALSE;
    else s = LIT_NULL;
    return s;
  endfunction

  // zero means the byte does not fit the leaf
  function automatic logic [5:0] leaf_step(input logic [5:0] s, input logic [7:0] c);
    logic [5:0] r;
    logic [7:0] e;
    logic       expo;
    r = S_NONE;
    e = lit_next(6'(s - LIT_BASE));
    expo = (c == CH_LE) || (c == CH_UE);
    case (s)
      S_OPEN: r = (c == CH_BSL) ? S_ESC : ((c == CH_QUOTE) ? S_CLOSED : S_OPEN);
      S_ESC: begin
        if (c == CH_LU) r = S_U0;
        else if (c == CH_LB || c == CH_LF || c == CH_LN || c == CH_LR || c == CH_LT ||
                 c == CH_QUOTE || c == CH_BSL) r = S_OPEN;
      end
      S_U0, S_U1, S_U2: r = is_hex(c) ? 6'(s + 6'd1) : S_NONE;
      S_U3: r = is_hex(c) ? S_OPEN : S_NONE;
      N_NEG: r = is_dig(c) ? ((c == CH_0) ? N_ZERO : N_INT) : S_NONE;
      N_INT: begin
        if (is_dig(c)) r = N_INT;
        else if (c == CH_DOT) r = N_DEC;
        else if (expo) r = N_EXP;
      end
      N_ZERO: begin
        if (c == CH_DOT) r = N_DEC;
        else if (expo) r = N_EXP;
      end
      N_DEC: r = is_dig(c) ? N_FRAC : S_NONE;
      N_FRAC: begin
        if (is_dig(c)) r = N_FRAC;
        else if (expo) r = N_EXP;
      end
      N_EXP: begin
        if (c == CH_PLUS || c == CH_MINUS) r = N_ESIGN;
        else if (is_dig(c)) r = N_EDIG;
      end
      N_ESIGN, N_EDIG: r = is_dig(c) ? N_EDIG : S_NONE;
      default: begin
        if (s >= LIT_BASE && s < 6'(LIT_BASE + LIT_COUNT) && e != 8'h00 && c == e)
          r = 6'(s + 6'd1);
      end
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/jsc_step.sv =====
module jsc_step (
  input  jsc_pkg::state_t cur_i,
  input  jsc_pkg::frame_t below_i,
  input  logic [7:0]      char_i,
  output jsc_pkg::state_t nxt_o,
  output jsc_pkg::push_t  push_o,
  output logic [1:0]      verdict_o,
  output logic            doc_valid_o
);
  import jsc_pkg::*;

  logic [7:0] closer;
  logic [7:0] pcloser;
  kind_e      kind;
  logic [5:0] ns;
  logic       deep;
  logic       ws;
  logic       sep;
  verdict_e   vd;
  state_t     nxt;
  push_t      push;

  always_comb begin
    nxt     = cur_i;
    push    = '0;
    vd      = V_REJ;
    closer  = cur_i.top.obj ? CH_RBRACE : CH_RBRACK;
    pcloser = below_i.obj ? CH_RBRACE : CH_RBRACK;
    kind    = value_kind(char_i);
    ns      = leaf_step(cur_i.leaf_state, char_i);
    deep    = cur_i.level >= LEVEL_W'(MAX_DEPTH);
    ws      = is_ws(char_i);
    sep     = char_i == CH_COMMA;

    if (cur_i.leaf_active) begin
      if (ns != S_NONE) begin
        vd = V_ACC;
        if (cur_i.level != '0 && cur_i.top.ph == PH_KEY && ns == S_CLOSED) begin
          nxt.leaf_active = 1'b0;
          nxt.leaf_state  = S_NONE;
          nxt.top         = '{obj: 1'b1, ph: PH_COLON};
        end else begin
          nxt.leaf_state = ns;
        end
      end else if (cur_i.level != '0 && cur_i.top.ph == PH_VALUE &&
                   leaf_valid(cur_i.leaf_state)) begin
        // leaf refused the byte, parent may take it
        if (ws) begin
          vd = V_WS;
        end else if (char_i == closer || sep) begin
          vd = V_ACC;
          nxt.leaf_active = 1'b0;
          nxt.leaf_state  = S_NONE;
          nxt.top.ph      = sep ? PH_AWAIT : PH_CLOSED;
        end
      end
    end else if (cur_i.level == '0) begin
      if (!cur_i.root_chosen) begin
        if (ws) begin
          vd = V_ACC;
        end else if (kind != K_NONE) begin
          vd = V_ACC;
          nxt.root_chosen = 1'b1;
          if (kind == K_ARRAY || kind == K_OBJECT) begin
            nxt.top   = '{obj: kind == K_OBJECT, ph: PH_OPEN};
            nxt.level = LEVEL_W'(1);
          end else begin
            nxt.leaf_state  = leaf_start(char_i);
            nxt.leaf_active = 1'b1;
          end
        end
      end
    end else begin
      unique case (cur_i.top.ph)
        PH_OPEN, PH_AWAIT, PH_VWAIT: begin
          if (cur_i.top.ph == PH_OPEN && char_i == closer) begin
            vd = V_ACC;
            nxt.top.ph = PH_CLOSED;
          end else if (ws) begin
            vd = V_WS;
          end else if (cur_i.top.obj && cur_i.top.ph != PH_VWAIT) begin
            if (char_i == CH_QUOTE) begin
              vd = V_ACC;
              nxt.leaf_state  = S_OPEN;
              nxt.leaf_active = 1'b1;
              nxt.top.ph      = PH_KEY;
            end
          end else if (kind == K_ARRAY || kind == K_OBJECT) begin
            if (deep) begin
              vd = V_DEEP;
            end else begin
              vd = V_ACC;
              push.we    = 1'b1;
              push.frame = '{obj: cur_i.top.obj, ph: PH_VALUE};
              nxt.top    = '{obj: kind == K_OBJECT, ph: PH_OPEN};
              nxt.level  = LEVEL_W'(cur_i.level + LEVEL_W'(1));
            end
          end else if (kind != K_NONE) begin
            vd = V_ACC;
            nxt.top.ph      = PH_VALUE;
            nxt.leaf_state  = leaf_start(char_i);
            nxt.leaf_active = 1'b1;
          end
        end
        PH_COLON: begin
          if (ws) begin
            vd = V_WS;
          end else if (char_i == CH_COLON) begin
            vd = V_ACC;
            nxt.top.ph = PH_VWAIT;
          end
        end
        PH_CLOSED: begin
          // closed child goes back to its parent
          if (cur_i.level != LEVEL_W'(1)) begin
            if (ws) begin
              vd = V_WS;
            end else if (char_i == pcloser || sep) begin
              vd = V_ACC;
              nxt.level = LEVEL_W'(cur_i.level - LEVEL_W'(1));
              nxt.top   = '{obj: below_i.obj, ph: sep ? PH_AWAIT : PH_CLOSED};
            end
          end
        end
        default: vd = V_REJ;
      endcase
    end
  end

  assign nxt_o       = nxt;
  assign push_o      = push;
  assign verdict_o   = vd;
  assign doc_valid_o = (nxt.level == LEVEL_W'(1) && nxt.top.ph == PH_CLOSED) ||
                       (nxt.leaf_active && nxt.level == '0 && leaf_valid(nxt.leaf_state));

endmodule

// ===== hw/rtl/json_stream_syntax_checker.sv =====
// JSON syntax checker, one byte per beat.
// Input channel in_valid_i/in_ready_o carries in_data_i: a restart flag, which clears
// the checker before its byte is looked at, and the byte itself.
// Output channel out_valid_o/out_ready_i carries out_data_o: the verdict (accepted,
// whitespace skipped, rejected, rejected too deep), whether the bytes so far form one
// complete value, and the number of containers held on the stack.
// Every input beat gives exactly one output beat, in order.
// An accepted byte is held in the input register, then the check logic writes its
// result into the output register. Throughput: one byte per cycle while out_ready_i
// stays high; the stack top is held in a register and the frames below it in a flop
// array read at one address, so each byte needs one pass.
// A rejected byte leaves all checker state as it was, unless its restart flag cleared it.
// When the receiver stalls, the held output and one input beat stay registered and
// in_ready_o drops; nothing is lost. Up to two beats are in flight.
// Reset clears the checker to empty and drops both valids; the stack array needs no clear.
module json_stream_syntax_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  jsc_pkg::in_beat_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output jsc_pkg::out_beat_t  out_data_o
);
  import jsc_pkg::*;

  logic       s1_vld_q;
  in_beat_t   s1_q;
  logic       s1_go;
  logic       out_vld_q;
  out_beat_t  out_q;
  state_t     state_q;
  state_t     state_d;
  state_t     cur;
  frame_t     stack_q [MAX_DEPTH];
  frame_t     below;
  push_t      push;
  logic [1:0] verdict;
  logic       doc_valid;
  logic [LEVEL_W-1:0] below_lvl;
  logic [LEVEL_W-1:0] top_lvl;

  assign s1_go      = s1_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !s1_vld_q || s1_go;

  assign cur       = s1_q.restart ? STATE_RESET : state_q;
  assign below_lvl = LEVEL_W'(cur.level - LEVEL_W'(2));
  assign top_lvl   = LEVEL_W'(cur.level - LEVEL_W'(1));
  assign below     = stack_q[below_lvl[IDX_W-1:0]];

  jsc_step u_step (
    .cur_i       (cur),
    .below_i     (below),
    .char_i      (s1_q.char_in),
    .nxt_o       (state_d),
    .push_o      (push),
    .verdict_o   (verdict),
    .doc_valid_o (doc_valid)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= STATE_RESET;
    end else begin
      if (in_ready_o) s1_vld_q <= in_valid_i;
      if (s1_go) begin
        out_vld_q <= 1'b1;
        state_q   <= state_d;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) s1_q <= in_data_i;
    if (s1_go) begin
      out_q.verdict    <= verdict;
      out_q.doc_valid  <= doc_valid;
      out_q.nest_depth <= NEST_W'(state_d.level);
    end
    // old top moves down when a child container opens
    if (s1_go && push.we) stack_q[top_lvl[IDX_W-1:0]] <= push.frame;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_rej_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go && !s1_q.restart && (verdict == V_REJ || verdict == V_DEEP)
    |=> state_q == $past(state_q))
    else $error("rejected byte changed checker state");

  a_deep_at_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go && verdict == V_DEEP |-> cur.level == LEVEL_W'(MAX_DEPTH))
    else $error("too deep flagged below max depth");

  a_depth_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.level <= LEVEL_W'(MAX_DEPTH))
    else $error("nesting level out of range");

  a_doc_shallow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.doc_valid |-> out_q.nest_depth <= NEST_W'(1))
    else $error("complete document reported with open containers");
`endif

endmodule

// ===== tb/json_syntax_scoreboard.sv =====
`timescale 1ns / 100ps

module json_syntax_scoreboard (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  jsc_pkg::in_beat_t   in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  jsc_pkg::out_beat_t  out_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  import jsc_pkg::*;

  localparam int unsigned OBJ_FLAG = 16;

  logic [4:0] frames[MAX_DEPTH];
  int unsigned depth;
  kind_e       root;
  logic [5:0]  leaf;
  logic        leaf_on;
  out_beat_t   verdicts_due[$];
  int          fails;

  function automatic logic ws_byte(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic hexdig(input logic [7:0] c);
    return digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic kind_e kind_of(input logic [7:0] c);
    if (c == "[") return K_ARRAY;
    if (c == "{") return K_OBJECT;
    if (c == "\"") return K_STRING;
    if (c == "-" || digit(c)) return K_NUMBER;
    if (c == "t" || c == "f" || c == "n") return K_LITERAL;
    return K_NONE;
  endfunction

  function automatic logic leaf_done(input logic [5:0] s);
    return s == S_CLOSED || s == N_ZERO || s == N_INT || s == N_FRAC || s == N_EDIG ||
           s == LIT_TRUE_END || s == LIT_FALSE_END || s == LIT_NULL_END;
  endfunction

  function automatic logic [5:0] leaf_next(input logic [5:0] s, input logic [7:0] c);
    logic [7:0] want;
    case (s)
      S_OPEN: return c == "\\" ? S_ESC : (c == "\"" ? S_CLOSED : S_OPEN);
      S_ESC: begin
        if (c == "u") return S_U0;
        if (c == "b" || c == "f" || c == "n" || c == "r" || c == "t" || c == "\"" ||
            c == "\\") return S_OPEN;
        return S_NONE;
      end
      S_U0, S_U1, S_U2: return hexdig(c) ? s + 6'd1 : S_NONE;
      S_U3: return hexdig(c) ? S_OPEN : S_NONE;
      N_NEG: return digit(c) ? (c == "0" ? N_ZERO : N_INT) : S_NONE;
      N_INT, N_ZERO: begin
        if (s == N_INT && digit(c)) return N_INT;
        if (c == ".") return N_DEC;
        return (c == "e" || c == "E") ? N_EXP : S_NONE;
      end
      N_DEC: return digit(c) ? N_FRAC : S_NONE;
      N_FRAC: begin
        if (digit(c)) return N_FRAC;
        return (c == "e" || c == "E") ? N_EXP : S_NONE;
      end
      N_EXP: begin
        if (c == "+" || c == "-") return N_ESIGN;
        return digit(c) ? N_EDIG : S_NONE;
      end
      N_ESIGN, N_EDIG: return digit(c) ? N_EDIG : S_NONE;
      default: ;
    endcase
    // literal words: prefixes of true, false, null laid out back to back
    if (s >= LIT_BASE && s < LIT_BASE + LIT_COUNT) begin
      case (s - LIT_BASE)
        0: want = "r"; 1: want = "u"; 2: want = "e";
        4: want = "a"; 5: want = "l"; 6: want = "s"; 7: want = "e";
        9: want = "u"; 10: want = "l"; 11: want = "l";
        default: want = 8'h00;
      endcase
      if (want != 8'h00 && c == want) return s + 6'd1;
    end
    return S_NONE;
  endfunction

  function automatic logic [1:0] open_value(input logic [7:0] c);
    kind_e k;
    k = kind_of(c);
    if (k == K_ARRAY || k == K_OBJECT) begin
      if (depth >= MAX_DEPTH) return V_DEEP;
      frames[depth] = (k == K_OBJECT) ? 5'(OBJ_FLAG | PH_OPEN) : 5'(PH_OPEN);
      depth++;
      return V_ACC;
    end
    if (c == "\"") leaf = S_OPEN;
    else if (c == "-") leaf = N_NEG;
    else if (c == "0") leaf = N_ZERO;
    else if (digit(c)) leaf = N_INT;
    else if (c == "t") leaf = LIT_BASE;
    else if (c == "f") leaf = LIT_FALSE;
    else leaf = LIT_NULL;
    leaf_on = 1'b1;
    return V_ACC;
  endfunction

  function automatic logic [1:0] child_done(input int unsigned p, input logic [7:0] c,
                                            input logic ok);
    logic [4:0] f;
    logic [7:0] closer;
    f = frames[p];
    closer = f[4] ? "}" : "]";
    if (!ok) return V_REJ;
    if (ws_byte(c)) return V_WS;
    if (c != closer && c != ",") return V_REJ;
    if (leaf_on) begin
      leaf_on = 1'b0;
      leaf = S_NONE;
    end else begin
      depth = p + 1;
    end
    frames[p] = {f[4], (c == ",") ? PH_AWAIT : PH_CLOSED};
    return V_ACC;
  endfunction

  function automatic logic [1:0] take_byte(input logic [7:0] c);
    logic [5:0]  ns;
    int unsigned t;
    logic [4:0]  f;
    logic [1:0]  v;
    kind_e       k;
    if (leaf_on) begin
      ns = leaf_next(leaf, c);
      if (ns != S_NONE) begin
        if (depth > 0 && frames[depth-1][3:0] == PH_KEY && ns == S_CLOSED) begin
          leaf_on = 1'b0;
          leaf = S_NONE;
          frames[depth-1] = 5'(OBJ_FLAG | PH_COLON);
        end else begin
          leaf = ns;
        end
        return V_ACC;
      end
      if (depth == 0) return V_REJ;
      if (frames[depth-1][3:0] != PH_VALUE) return V_REJ;
      return child_done(depth - 1, c, leaf_done(leaf));
    end
    if (depth == 0) begin
      if (root != K_NONE) return V_REJ;
      if (ws_byte(c)) return V_ACC;
      k = kind_of(c);
      if (k == K_NONE) return V_REJ;
      v = open_value(c);
      if (v == V_ACC) root = k;
      return v;
    end
    t = depth - 1;
    f = frames[t];
    case (f[3:0])
      PH_OPEN, PH_AWAIT: begin
        if (f[3:0] == PH_OPEN && c == (f[4] ? "}" : "]")) begin
          frames[t] = {f[4], PH_CLOSED};
          return V_ACC;
        end
        if (ws_byte(c)) return V_WS;
        if (f[4]) begin
          if (c != "\"") return V_REJ;
          leaf = S_OPEN;
          leaf_on = 1'b1;
          frames[t] = 5'(OBJ_FLAG | PH_KEY);
          return V_ACC;
        end
        if (kind_of(c) == K_NONE) return V_REJ;
        v = open_value(c);
        if (v == V_ACC) frames[t] = 5'(PH_VALUE);
        return v;
      end
      PH_COLON: begin
        if (ws_byte(c)) return V_WS;
        if (c != ":") return V_REJ;
        frames[t] = 5'(OBJ_FLAG | PH_VWAIT);
        return V_ACC;
      end
      PH_VWAIT: begin
        if (ws_byte(c)) return V_WS;
        if (kind_of(c) == K_NONE) return V_REJ;
        v = open_value(c);
        if (v == V_ACC) frames[t] = 5'(OBJ_FLAG | PH_VALUE);
        return v;
      end
      PH_CLOSED: begin
        if (t == 0) return V_REJ;
        return child_done(t - 1, c, 1'b1);
      end
      default: return V_REJ;
    endcase
  endfunction

  function automatic logic whole_doc();
    if (root == K_ARRAY || root == K_OBJECT)
      return depth > 0 && frames[0][3:0] == PH_CLOSED;
    if (root != K_NONE) return leaf_on && depth == 0 && leaf_done(leaf);
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t exp_beat;
    if (!rst_ni) begin
      depth = 0;
      root = K_NONE;
      leaf = S_NONE;
      leaf_on = 1'b0;
      verdicts_due.delete();
      fails = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (verdicts_due.size() == 0) begin
          $error("output beat with nothing expected: %p", out_data_i);
          fails++;
        end else begin
          exp_beat = verdicts_due.pop_front();
          if (out_data_i.verdict !== exp_beat.verdict) begin
            $error("verdict: expected %0d, got %0d", exp_beat.verdict, out_data_i.verdict);
            fails++;
          end
          if (out_data_i.doc_valid !== exp_beat.doc_valid) begin
            $error("doc_valid: expected %0d, got %0d", exp_beat.doc_valid,
                   out_data_i.doc_valid);
            fails++;
          end
          if (out_data_i.nest_depth !== exp_beat.nest_depth) begin
            $error("nest_depth: expected %0d, got %0d", exp_beat.nest_depth,
                   out_data_i.nest_depth);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.restart) begin
          depth = 0;
          root = K_NONE;
          leaf = S_NONE;
          leaf_on = 1'b0;
        end
        exp_beat.verdict = take_byte(in_data_i.char_in);
        exp_beat.doc_valid = whole_doc();
        exp_beat.nest_depth = NEST_W'(depth);
        verdicts_due = {verdicts_due, exp_beat};
      end
    end
  end

  assign fail_count_o = fails;
  assign pending_o = verdicts_due.size();
endmodule

// ===== tb/json_stream_syntax_checker_tb.sv =====
`timescale 1ns / 100ps

module json_stream_syntax_checker_tb;
  import jsc_pkg::*;

  localparam int STALL_LIMIT = 2000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_data;
  int        fail_count;
  int        pending;
  logic      calm;
  int        idle_cycles;
  int        beats_sent;

  json_stream_syntax_checker uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  json_syntax_scoreboard checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= calm || ($urandom_range(99) >= 32);
  end

  // watchdog: cycles with no beat on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // valid stays up after the beat; the next beat or an idle cycle replaces it
  task automatic send_byte(input logic [7:0] c, input logic rs);
    while (!calm && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{restart: rs, char_in: c};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_text(input string s, input logic rs);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], rs && i == 0);
  endtask

  function automatic string pick(input string opts[]);
    return opts[$urandom_range(opts.size() - 1)];
  endfunction

  // random well-formed value, nesting bounded by lvl
  function automatic string make_value(input int lvl);
    string s;
    int n;
    int kind;
    kind = (lvl > 0) ? $urandom_range(7) : $urandom_range(4);
    case (kind)
      0: s = pick('{"0", "-12", "3.25", "-0.5e+7", "17E-2", "908", "1e9"});
      1: s = pick('{"true", "false", "null"});
      2: s = pick('{"\"\"", "\"ab\\n\"", "\"\\u0aF9x\"", "\"\\\"\\\\\\t\"",
                     "\"\\b\\f\\r\"", "\"\\u12AB\""});
      3: begin
        s = "\"";
        n = $urandom_range(4);
        for (int i = 0; i < n; i++) begin
          byte b;
          b = $urandom_range(255);
          if (b == "\"" || b == "\\") b = "z";
          s = {s, string'(b)};
        end
        s = {s, "\""};
      end
      4: s = pick('{"0", "42", "-7"});
      5, 6: begin
        n = $urandom_range(3);
        s = "[";
        for (int i = 0; i < n; i++)
          s = {s, (i ? pick('{",", " , ", ",\n"}) : " "), make_value(lvl - 1)};
        s = {s, "]"};
      end
      default: begin
        n = $urandom_range(3);
        s = "{";
        for (int i = 0; i < n; i++)
          s = {s, (i ? "," : ""), " \"k", string'(8'("a" + i)), "\"\t:",
               make_value(lvl - 1)};
        s = {s, "}"};
      end
    endcase
    return s;
  endfunction

  initial begin
    string doc;
    int pos;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    calm = 1'b0;
    beats_sent = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: leading space, split number, solidus escape, trailing bytes
    send_text(" [1 2, \"a\\/\\u00Ff\\q\"] x", 1'b1);
    send_text("{\"k\":true,\"n\":-0.5E+3}", 1'b1);
    send_byte(8'hFF, 1'b0);
    send_text("\"\x01\xFF\"", 1'b1);
    send_text("nul", 1'b1);
    send_byte(8'h00, 1'b0);
    send_text("l ", 1'b0);
    // too deep: one bracket past the limit, then unwind
    send_byte("[", 1'b1);
    for (int i = 1; i <= MAX_DEPTH; i++) send_byte("[", 1'b0);
    for (int i = 0; i < MAX_DEPTH; i++) send_byte("]", 1'b0);
    send_byte("{", 1'b1);
    for (int i = 1; i < MAX_DEPTH; i++) send_text("\"\":{", 1'b0);
    send_text("\"\":{}", 1'b0);

    // random: mostly well-formed documents, some with corrupted bytes
    while (beats_sent < 400) begin
      calm = (beats_sent >= 280 && beats_sent < 360);
      doc = make_value(4);
      if ($urandom_range(3) == 0) begin
        pos = $urandom_range(doc.len() - 1);
        doc[pos] = $urandom_range(255);
      end
      if ($urandom_range(4) == 0) doc = {doc, pick('{" ", "1", "]", "x"})};
      send_text(doc, 1'b1);
    end
    send_byte(8'h80, 1'b1);
    send_byte(8'h7F, 1'b0);
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("sent %0d bytes: directed edge cases, full-depth nesting and random documents",
             beats_sent);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
